### hw/rtl/acvb_pkg.sv
// Shared types and constants for the associative cache with victim buffer.
package acvb_pkg;

   localparam int MAIN_LINES_DEF   = 4;
   localparam int VICTIM_LINES_DEF = 2;
   localparam int BLOCK_BITS_DEF   = 24;

   // Fixed field widths of the request and response streams
   localparam int BLOCK_W    = 24;
   localparam int OUTCOME_W  = 2;
   localparam int LINE_W     = 2;
   localparam int COUNT_W    = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 128;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_MAIN_HIT   = 2'd0,
      OUTCOME_VICTIM_HIT = 2'd1,
      OUTCOME_MISS       = 2'd2
   } outcome_type;

   // One-cycle strobes, one per outcome, raised for each request that completes
   typedef struct packed {
      logic main_hit;
      logic victim_hit;
      logic miss;
   } count_event_type;

endpackage

### hw/rtl/acvb_lookup.sv
// Parallel tag compare and replacement line pick over one tag store.
module acvb_lookup #(
   parameter int LINES    = acvb_pkg::MAIN_LINES_DEF,
   parameter int TAG_BITS = acvb_pkg::BLOCK_BITS_DEF,
   localparam int IDX_W   = (LINES > 1) ? $clog2(LINES) : 1
) (
   input  logic [TAG_BITS-1:0] tags [LINES],
   input  logic [LINES-1:0]    valid,
   input  logic [TAG_BITS-1:0] tag,
   output logic                hit,
   output logic [IDX_W-1:0]    hit_idx,
   output logic [IDX_W-1:0]    free_idx
);

   logic [LINES-1:0] match;

   always_comb begin
      for (int i = 0; i < LINES; i++) begin
         match[i] = valid[i] && (tags[i] == tag);
      end
   end

   assign hit = |match;

   // Walk downwards so that the lowest matching or invalid entry wins
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = LINES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

endmodule

### hw/rtl/acvb_counters.sv
// Saturating outcome counters.
module acvb_counters (
   input  logic                            clock,
   input  logic                            reset,
   input  acvb_pkg::count_event_type       evt,
   output logic [acvb_pkg::COUNT_W-1:0]    main_hit_count,
   output logic [acvb_pkg::COUNT_W-1:0]    victim_hit_count,
   output logic [acvb_pkg::COUNT_W-1:0]    miss_count
);

   logic [acvb_pkg::COUNT_W-1:0] main_hits_ff,   main_hits_in;
   logic [acvb_pkg::COUNT_W-1:0] victim_hits_ff, victim_hits_in;
   logic [acvb_pkg::COUNT_W-1:0] misses_ff,      misses_in;

   // Hold at the top value once reached
   always_comb begin
      main_hits_in   = main_hits_ff;
      victim_hits_in = victim_hits_ff;
      misses_in      = misses_ff;
      if (evt.main_hit && (main_hits_ff != acvb_pkg::COUNT_MAX)) begin
         main_hits_in = main_hits_ff + 1'b1;
      end
      if (evt.victim_hit && (victim_hits_ff != acvb_pkg::COUNT_MAX)) begin
         victim_hits_in = victim_hits_ff + 1'b1;
      end
      if (evt.miss && (misses_ff != acvb_pkg::COUNT_MAX)) begin
         misses_in = misses_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_hits_ff   <= '0;
         victim_hits_ff <= '0;
         misses_ff      <= '0;
      end else begin
         main_hits_ff   <= main_hits_in;
         victim_hits_ff <= victim_hits_in;
         misses_ff      <= misses_in;
      end
   end

   assign main_hit_count   = main_hits_ff;
   assign victim_hit_count = victim_hits_ff;
   assign miss_count       = misses_ff;

endmodule

### hw/rtl/associative_cache_with_victim_buffer.sv
// Top level of the fully associative cache tag array with a victim buffer.
//
// Each request carries one block number. It is looked up in a fully associative
// main tag store of MAIN_LINES entries and, on a main miss, in a victim store of
// VICTIM_LINES entries. A victim hit swaps that entry with the main replacement
// line; a miss in both fills the replacement line and pushes the displaced
// valid tag into the victim store, possibly dropping an older victim. The
// replacement line of either store is its lowest invalid entry, or entry 0 once
// the store is full. Every request yields one response with the outcome, the
// main line used, the dropped victim tag if any, and three saturating 32-bit
// outcome counters as they stand after this request. A request is registered
// on entry, resolved by the parallel tag compare of both stores once the
// response register is free or drains, and its response registered at the
// same edge at which the stores and counters update; one request completes
// every cycle while the response side keeps up. Tags and valid bits live in
// flip-flops; valid bits clear on reset, and no initialisation pass is needed.
module associative_cache_with_victim_buffer #(
   parameter int MAIN_LINES   = acvb_pkg::MAIN_LINES_DEF,
   parameter int VICTIM_LINES = acvb_pkg::VICTIM_LINES_DEF,
   parameter int BLOCK_BITS   = acvb_pkg::BLOCK_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [23:0] block_number
   input  logic [acvb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] outcome, [3:2] main_line, [4] victim_dropped, [28:5] dropped_block,
   // [60:29] main_hit_count, [92:61] victim_hit_count, [124:93] miss_count,
   // [127:125] zero
   output logic [acvb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int MIDX_W     = (MAIN_LINES > 1) ? $clog2(MAIN_LINES) : 1;
   localparam int VIDX_W     = (VICTIM_LINES > 1) ? $clog2(VICTIM_LINES) : 1;
   localparam int TAG_EXT_W  = (BLOCK_BITS > acvb_pkg::BLOCK_W) ? BLOCK_BITS
                                                                 : acvb_pkg::BLOCK_W;
   localparam int LINE_EXT_W = (MIDX_W > acvb_pkg::LINE_W) ? MIDX_W : acvb_pkg::LINE_W;
   localparam int PAD_W      = acvb_pkg::RSP_DATA_W - acvb_pkg::OUTCOME_W
                               - acvb_pkg::LINE_W - 1 - acvb_pkg::BLOCK_W
                               - 3 * acvb_pkg::COUNT_W;

   // ---------------------------------------------------------------------
   // Handshake: input register feeding the response register
   // ---------------------------------------------------------------------
   logic                  in_valid_ff,  in_valid_in;
   logic [BLOCK_BITS-1:0] in_block_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;
   logic                  req_take;
   logic [TAG_EXT_W-1:0]  req_block_ext;

   // Resolve the held request whenever the response register is free or drains
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // Drop block number bits above BLOCK_BITS
   assign req_block_ext = TAG_EXT_W'(req_tdata[acvb_pkg::BLOCK_W-1:0]);

   // ---------------------------------------------------------------------
   // Tag stores
   // ---------------------------------------------------------------------
   logic [BLOCK_BITS-1:0]   main_tags_ff   [MAIN_LINES];
   logic [BLOCK_BITS-1:0]   main_tags_in   [MAIN_LINES];
   logic [MAIN_LINES-1:0]   main_valid_ff,   main_valid_in;
   logic [BLOCK_BITS-1:0]   victim_tags_ff [VICTIM_LINES];
   logic [BLOCK_BITS-1:0]   victim_tags_in [VICTIM_LINES];
   logic [VICTIM_LINES-1:0] victim_valid_ff, victim_valid_in;

   logic              m_hit;
   logic [MIDX_W-1:0] m_hit_idx;
   logic [MIDX_W-1:0] m_free_idx;
   logic              v_hit;
   logic [VIDX_W-1:0] v_hit_idx;
   logic [VIDX_W-1:0] v_free_idx;

   acvb_lookup #(
      .LINES    (MAIN_LINES),
      .TAG_BITS (BLOCK_BITS)
   ) u_main_lookup (
      .tags     (main_tags_ff),
      .valid    (main_valid_ff),
      .tag      (in_block_ff),
      .hit      (m_hit),
      .hit_idx  (m_hit_idx),
      .free_idx (m_free_idx)
   );

   acvb_lookup #(
      .LINES    (VICTIM_LINES),
      .TAG_BITS (BLOCK_BITS)
   ) u_victim_lookup (
      .tags     (victim_tags_ff),
      .valid    (victim_valid_ff),
      .tag      (in_block_ff),
      .hit      (v_hit),
      .hit_idx  (v_hit_idx),
      .free_idx (v_free_idx)
   );

   // ---------------------------------------------------------------------
   // Resolve the held request: main hit, victim swap or fill
   // ---------------------------------------------------------------------
   acvb_pkg::outcome_type     outcome_in;
   logic [MIDX_W-1:0]         line_idx;
   logic                      dropped_in;
   logic [BLOCK_BITS-1:0]     dropped_tag;
   acvb_pkg::count_event_type evt;

   always_comb begin
      main_tags_in    = main_tags_ff;
      main_valid_in   = main_valid_ff;
      victim_tags_in  = victim_tags_ff;
      victim_valid_in = victim_valid_ff;
      outcome_in      = acvb_pkg::OUTCOME_MAIN_HIT;
      line_idx        = m_hit_idx;
      dropped_in      = 1'b0;
      dropped_tag     = '0;
      evt             = '0;
      if (m_hit) begin
         // Tags untouched on a main hit
         evt.main_hit = advance;
      end else if (v_hit) begin
         // Swap the victim entry with the main replacement line
         outcome_in                 = acvb_pkg::OUTCOME_VICTIM_HIT;
         line_idx                   = m_free_idx;
         main_tags_in[m_free_idx]   = victim_tags_ff[v_hit_idx];
         main_valid_in[m_free_idx]  = 1'b1;
         victim_tags_in[v_hit_idx]  = main_tags_ff[m_free_idx];
         victim_valid_in[v_hit_idx] = main_valid_ff[m_free_idx];
         evt.victim_hit             = advance;
      end else begin
         // Fill; demote a valid displaced tag into the victim store
         outcome_in = acvb_pkg::OUTCOME_MISS;
         line_idx   = m_free_idx;
         if (main_valid_ff[m_free_idx]) begin
            if (victim_valid_ff[v_free_idx]) begin
               dropped_in  = 1'b1;
               dropped_tag = victim_tags_ff[v_free_idx];
            end
            victim_tags_in[v_free_idx]  = main_tags_ff[m_free_idx];
            victim_valid_in[v_free_idx] = 1'b1;
         end
         main_tags_in[m_free_idx]  = in_block_ff;
         main_valid_in[m_free_idx] = 1'b1;
         evt.miss                  = advance;
      end
   end

   // ---------------------------------------------------------------------
   // Counters
   // ---------------------------------------------------------------------
   logic [acvb_pkg::COUNT_W-1:0] main_hit_count;
   logic [acvb_pkg::COUNT_W-1:0] victim_hit_count;
   logic [acvb_pkg::COUNT_W-1:0] miss_count;

   // Counters move only at an advance, so they always match the response held
   acvb_counters u_counters (
      .clock            (clock),
      .reset            (reset),
      .evt              (evt),
      .main_hit_count   (main_hit_count),
      .victim_hit_count (victim_hit_count),
      .miss_count       (miss_count)
   );

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [LINE_EXT_W-1:0]          line_ext;
   logic [TAG_EXT_W-1:0]           dropped_ext;
   acvb_pkg::outcome_type          rsp_outcome_ff;
   logic [acvb_pkg::LINE_W-1:0]    rsp_line_ff;
   logic                           rsp_dropped_ff;
   logic [acvb_pkg::BLOCK_W-1:0]   rsp_dropped_block_ff;

   assign line_ext    = LINE_EXT_W'(line_idx);
   assign dropped_ext = TAG_EXT_W'(dropped_tag);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         main_valid_ff   <= '0;
         victim_valid_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            main_valid_ff   <= main_valid_in;
            victim_valid_ff <= victim_valid_in;
         end
      end
   end

   // Payload and tags need no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_block_ff <= req_block_ext[BLOCK_BITS-1:0];
      end
      if (advance) begin
         main_tags_ff         <= main_tags_in;
         victim_tags_ff       <= victim_tags_in;
         rsp_outcome_ff       <= outcome_in;
         rsp_line_ff          <= line_ext[acvb_pkg::LINE_W-1:0];
         rsp_dropped_ff       <= dropped_in;
         rsp_dropped_block_ff <= dropped_ext[acvb_pkg::BLOCK_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, miss_count, victim_hit_count, main_hit_count,
                        rsp_dropped_block_ff, rsp_dropped_ff, rsp_line_ff,
                        rsp_outcome_ff};

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Main lines never lose their valid bit
   a_main_valid_sticky : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((main_valid_ff & $past(main_valid_ff)) == $past(main_valid_ff)))
      else $error("main store lost a valid bit");

   // Victim store fills only once the main store is full
   a_victim_needs_full_main : assert property (@(posedge clock) disable iff (reset)
      (|victim_valid_ff) |-> (&main_valid_ff))
      else $error("victim entry valid while main store has a free line");

   // A drop is reported only on a miss, and the dropped tag is zero otherwise
   a_drop_on_miss : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dropped_ff) |-> (rsp_outcome_ff == acvb_pkg::OUTCOME_MISS))
      else $error("victim drop reported outside a miss");

   a_drop_tag_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_dropped_ff) |-> (rsp_dropped_block_ff == '0))
      else $error("dropped block nonzero without a drop");

   // A held response freezes the stores
   a_stall_holds_state : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(main_valid_ff) && $stable(miss_count)))
      else $error("state moved while the response was stalled");

endmodule
